### rtl/timed_event_table_assert.svh
// Assertion macros used by the checker file.
`ifndef TIMED_EVENT_TABLE_ASSERT_SVH
`define TIMED_EVENT_TABLE_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define TET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TET_ASSERT_NEXT(label, pre, post, msg) \
  `TET_ASSERT(label, (pre) |=> (post), msg)

`endif

### rtl/tet_pkg.sv
package tet_pkg;

  localparam int unsigned EVENT_SLOTS_DEF   = 8;
  localparam int unsigned CHANNEL_COUNT_DEF = 4;
  localparam int unsigned MAX_RESULTS       = 8;

  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned SECOND_W   = 6;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SLOT_IDX_W = 3;
  localparam int unsigned CNT_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_WRITE    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    logic                operation;
    logic [HOUR_W-1:0]   hour_value;
    logic [MINUTE_W-1:0] minute_value;
    logic [SECOND_W-1:0] second_value;
    logic [CHAN_W-1:0]   channel_index;
    logic [LEVEL_W-1:0]  level_value;
  } in_word_t;

  typedef struct packed {
    kind_e                 result_kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [CHAN_W-1:0]     out_channel;
    logic [LEVEL_W-1:0]    out_level;
    logic                  last_result;
  } out_word_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [CHAN_W-1:0]   channel;
    logic [LEVEL_W-1:0]  level;
  } entry_t;

  typedef struct packed {
    logic  capture;
    logic  idx_step;
    logic  mem_write;
    logic  pend_load;
    logic  pend_clear;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cur_free;
    logic cur_match;
    logic idx_end;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

### rtl/tet_in_if.sv
interface tet_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [tet_pkg::HOUR_W-1:0]      hour_value;
  logic [tet_pkg::MINUTE_W-1:0]    minute_value;
  logic [tet_pkg::SECOND_W-1:0]    second_value;
  logic [tet_pkg::CHAN_W-1:0]      channel_index;
  logic [tet_pkg::LEVEL_W-1:0]     level_value;

  modport source (
    output valid, operation, hour_value, minute_value, second_value,
           channel_index, level_value,
    input  ready
  );

  modport sink (
    input  valid, operation, hour_value, minute_value, second_value,
           channel_index, level_value,
    output ready
  );
endinterface

### rtl/tet_out_if.sv
interface tet_out_if;
  logic                             valid;
  logic                             ready;
  logic [tet_pkg::KIND_W-1:0]       result_kind;
  logic [tet_pkg::SLOT_IDX_W-1:0]   slot_index;
  logic [tet_pkg::CHAN_W-1:0]       out_channel;
  logic [tet_pkg::LEVEL_W-1:0]      out_level;
  logic                             last_result;

  modport source (
    output valid, result_kind, slot_index, out_channel, out_level, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_kind, slot_index, out_channel, out_level, last_result,
    output ready
  );
endinterface

### rtl/tet_ctrl.sv
module tet_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tet_pkg::sts_t sts_i,
  output tet_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    logic advance;
    advance = 1'b0;
    state_d = state_q;
    cmd_o = '0;
    cmd_o.out_kind = tet_pkg::KIND_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!sts_i.is_tick) begin
          if (sts_i.cur_free) begin
            if (sts_i.out_free) begin
              cmd_o.mem_write = 1'b1;
              cmd_o.out_load  = 1'b1;
              cmd_o.out_kind  = tet_pkg::KIND_INSERTED;
              cmd_o.out_last  = 1'b1;
              state_d = ST_IDLE;
            end
          end else if (sts_i.idx_end) begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_kind = tet_pkg::KIND_FULL;
              cmd_o.out_last = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.idx_step = 1'b1;
          end
        end else begin
          // a held match goes out only once the next one shows it is not last
          if (sts_i.cur_match && sts_i.pend_valid) begin
            if (sts_i.out_free) begin
              cmd_o.out_load  = 1'b1;
              cmd_o.out_kind  = tet_pkg::KIND_WRITE;
              cmd_o.pend_load = 1'b1;
              advance = 1'b1;
            end
          end else begin
            cmd_o.pend_load = sts_i.cur_match;
            advance = 1'b1;
          end
          if (advance) begin
            if (sts_i.idx_end) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.idx_step = 1'b1;
            end
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_kind   = sts_i.pend_valid ? tet_pkg::KIND_WRITE : tet_pkg::KIND_NONE;
          cmd_o.pend_clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

### rtl/tet_dp.sv
module tet_dp #(
  parameter int unsigned EVENT_SLOTS   = tet_pkg::EVENT_SLOTS_DEF,
  parameter int unsigned CHANNEL_COUNT = tet_pkg::CHANNEL_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tet_pkg::cmd_t      cmd_i,
  output tet_pkg::sts_t      sts_o,
  input  tet_pkg::in_word_t  in_word_i,
  output tet_pkg::out_word_t out_word_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  localparam int unsigned SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EVENT_SLOTS - 1);
  localparam logic [tet_pkg::CHAN_W:0] CHAN_LIMIT = (tet_pkg::CHAN_W + 1)'(CHANNEL_COUNT);
  localparam logic [tet_pkg::CNT_W-1:0] CNT_LIMIT = tet_pkg::CNT_W'(tet_pkg::MAX_RESULTS);

  tet_pkg::in_word_t  word_q;
  logic [EVENT_SLOTS-1:0] used_q;
  tet_pkg::entry_t    mem [EVENT_SLOTS];
  tet_pkg::entry_t    rd_q;
  logic [SLOT_W-1:0]  idx_q, idx_d;

  logic                         pend_valid_q;
  logic [SLOT_W-1:0]            pend_slot_q;
  logic [tet_pkg::CHAN_W-1:0]   pend_chan_q;
  logic [tet_pkg::LEVEL_W-1:0]  pend_level_q;
  logic [tet_pkg::CNT_W-1:0]    cnt_q;

  logic               out_valid_q;
  tet_pkg::out_word_t out_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cmd_i.capture) begin
      idx_d = '0;
    end else if (cmd_i.idx_step) begin
      idx_d = idx_q + SLOT_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_comb begin
    sts_o.is_tick    = (word_q.operation == tet_pkg::OP_TICK);
    sts_o.cur_free   = !used_q[idx_q];
    sts_o.cur_match  = used_q[idx_q]
                       && (rd_q.hour == word_q.hour_value)
                       && (rd_q.minute == word_q.minute_value)
                       && ({1'b0, rd_q.channel} < CHAN_LIMIT)
                       && (word_q.second_value == '0)
                       && (cnt_q < CNT_LIMIT);
    sts_o.idx_end    = (idx_q == LAST_SLOT);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  // entry store; the read is registered from idx_d, so rd_q holds the entry at idx_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem[idx_q] <= '{hour:    word_q.hour_value,
                      minute:  word_q.minute_value,
                      channel: word_q.channel_index,
                      level:   word_q.level_value};
    end
    rd_q <= mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= in_word_i;
    end
    if (cmd_i.pend_load) begin
      pend_slot_q  <= idx_q;
      pend_chan_q  <= rd_q.channel;
      pend_level_q <= rd_q.level;
    end
    if (cmd_i.out_load) begin
      out_q.result_kind <= cmd_i.out_kind;
      out_q.last_result <= cmd_i.out_last;
      case (cmd_i.out_kind)
        tet_pkg::KIND_INSERTED: begin
          out_q.slot_index  <= tet_pkg::SLOT_IDX_W'(idx_q);
          out_q.out_channel <= '0;
          out_q.out_level   <= '0;
        end
        tet_pkg::KIND_WRITE: begin
          out_q.slot_index  <= tet_pkg::SLOT_IDX_W'(pend_slot_q);
          out_q.out_channel <= pend_chan_q;
          out_q.out_level   <= pend_level_q;
        end
        default: begin
          out_q.slot_index  <= '0;
          out_q.out_channel <= '0;
          out_q.out_level   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.mem_write) begin
        used_q[idx_q] <= 1'b1;
      end
      if (cmd_i.capture || cmd_i.pend_clear) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.capture) begin
        cnt_q <= '0;
      end else if (cmd_i.pend_load) begin
        cnt_q <= cnt_q + tet_pkg::CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

### rtl/timed_event_table.sv
// channel  modport  word
// in_i     sink     operation, hour, minute, second, channel, level
// out_o    source   kind, slot, channel, level, last
//
// Insert: accept the word, then scan the slots from slot 0 for the first free one.
// Tick: one slot per cycle through the entry read port, unless a result waits on the output register.
// Reset clears all used bits at once; no sweep over the entry store.
// Results sit in an output register; the scan waits only when a result is due
// and that register still holds an unaccepted word.
module timed_event_table #(
  parameter int unsigned EVENT_SLOTS   = tet_pkg::EVENT_SLOTS_DEF,
  parameter int unsigned CHANNEL_COUNT = tet_pkg::CHANNEL_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tet_in_if.sink    in_i,
  tet_out_if.source out_o
);

  tet_pkg::cmd_t      cmd;
  tet_pkg::sts_t      sts;
  tet_pkg::in_word_t  in_word;
  tet_pkg::out_word_t out_word;
  logic               ready;
  logic               out_valid;

  assign in_word = '{operation:     in_i.operation,
                     hour_value:    in_i.hour_value,
                     minute_value:  in_i.minute_value,
                     second_value:  in_i.second_value,
                     channel_index: in_i.channel_index,
                     level_value:   in_i.level_value};

  assign in_i.ready = ready;

  tet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tet_dp #(
    .EVENT_SLOTS   (EVENT_SLOTS),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word),
    .out_word_o  (out_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid       = out_valid;
  assign out_o.result_kind = out_word.result_kind;
  assign out_o.slot_index  = out_word.slot_index;
  assign out_o.out_channel = out_word.out_channel;
  assign out_o.out_level   = out_word.out_level;
  assign out_o.last_result = out_word.last_result;

endmodule

### rtl/tet_checker.sv
`include "timed_event_table_assert.svh"

module tet_checker #(
  parameter int unsigned CHANNEL_COUNT = tet_pkg::CHANNEL_COUNT_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  tet_in_if.sink    in_i,
  tet_out_if.source out_o
);

  localparam logic [tet_pkg::CHAN_W:0] CHAN_LIMIT = (tet_pkg::CHAN_W + 1)'(CHANNEL_COUNT);

  logic is_write;

  assign is_write = (out_o.result_kind == tet_pkg::KIND_WRITE);

  `TET_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready,
                   out_o.valid && $stable(out_o.result_kind) && $stable(out_o.out_channel),
                   "result word changed while stalled")

  `TET_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready,
                   "input still ready right after accepting a word")

  `TET_ASSERT(a_write_in_range,
              out_o.valid && is_write |-> ({1'b0, out_o.out_channel} < CHAN_LIMIT),
              "channel write outside channel range")

  `TET_ASSERT(a_other_zero,
              out_o.valid && !is_write |-> (out_o.out_channel == '0) && (out_o.out_level == '0),
              "non-write result carries channel or level")

endmodule

bind timed_event_table tet_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_tet_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tet_pkg::*;

  localparam int unsigned NSLOTS      = EVENT_SLOTS_DEF;
  localparam int unsigned RAND_WORDS  = 412;
  localparam int unsigned PHASE_WORDS = RAND_WORDS / 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 2 * NSLOTS + 8;
  localparam int unsigned NDIR        = 20;

  typedef struct {
    op_e         op;
    int unsigned hour, minute, second, chan, level;
    bit          typed;
    kind_e       kind;
    int unsigned slot;
  } dir_row_t;

  // op, hour, minute, second, channel, level, typed, kind, slot
  dir_row_t dir_rows [NDIR] = '{
    '{OP_TICK,    0,  0,  0,   0,   0, 1'b1, KIND_NONE,     0},  // empty table
    '{OP_TICK,   31, 63, 63, 255, 255, 1'b1, KIND_NONE,     0},
    '{OP_INSERT,  0,  0, 63,   0,   0, 1'b1, KIND_INSERTED, 0},
    '{OP_INSERT, 31, 63,  0,   3, 255, 1'b1, KIND_INSERTED, 1},  // raw time bits
    '{OP_INSERT, 12, 30,  0, 255, 170, 1'b1, KIND_INSERTED, 2},  // channel out of range
    '{OP_INSERT, 12, 30,  0,   1,  85, 1'b1, KIND_INSERTED, 3},
    '{OP_INSERT, 12, 30,  0,   4,   1, 1'b1, KIND_INSERTED, 4},  // first bad channel
    '{OP_TICK,   12, 30,  0,   0,   0, 1'b0, KIND_WRITE,    0},
    '{OP_TICK,   12, 30,  1,   0,   0, 1'b1, KIND_NONE,     0},  // second not zero
    '{OP_TICK,   12, 30, 59, 255, 255, 1'b1, KIND_NONE,     0},
    '{OP_TICK,   31, 63,  0,   0,   0, 1'b0, KIND_WRITE,    0},
    '{OP_TICK,    0,  0,  0, 255, 255, 1'b0, KIND_WRITE,    0},
    '{OP_TICK,   23, 59,  0,   0,   0, 1'b1, KIND_NONE,     0},
    '{OP_TICK,   12, 31,  0,   0,   0, 1'b1, KIND_NONE,     0},
    '{OP_INSERT, 12, 30, 17,   2, 255, 1'b1, KIND_INSERTED, 5},
    '{OP_INSERT, 12, 30,  0,   0,   7, 1'b1, KIND_INSERTED, 6},
    '{OP_INSERT, 31, 63,  0,   3, 128, 1'b1, KIND_INSERTED, 7},
    '{OP_INSERT,  0,  0,  0,   1,   9, 1'b1, KIND_FULL,     0},  // table full
    '{OP_TICK,   12, 30,  0,   0,   0, 1'b0, KIND_WRITE,    0},
    '{OP_TICK,   31, 63,  0, 170,  85, 1'b0, KIND_WRITE,    0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tet_in_if  in_if ();
  tet_out_if out_if ();

  timed_event_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // event table shadow
  logic              ev_busy   [NSLOTS];
  logic [HOUR_W-1:0] ev_hour   [NSLOTS];
  logic [MINUTE_W-1:0] ev_minute [NSLOTS];
  logic [CHAN_W-1:0]  ev_chan   [NSLOTS];
  logic [LEVEL_W-1:0] ev_level  [NSLOTS];

  out_word_t   awaited_results [$];
  int unsigned fail_cnt = 0;
  int unsigned n_sent = 0, n_ins = 0, n_full = 0, n_writes = 0, n_none = 0;
  int unsigned src_idle_pct = 0, sink_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  function automatic void event_table_step(input in_word_t w, output out_word_t res [$]);
    out_word_t r;
    bit        placed;
    int        s;
    res.delete();
    placed = 1'b0;
    if (w.operation == OP_INSERT) begin
      for (s = 0; s < NSLOTS; s++) begin
        if (!placed && !ev_busy[s]) begin
          ev_busy[s]   = 1'b1;
          ev_hour[s]   = w.hour_value;
          ev_minute[s] = w.minute_value;
          ev_chan[s]   = w.channel_index;
          ev_level[s]  = w.level_value;
          r = '{KIND_INSERTED, SLOT_IDX_W'(s), '0, '0, 1'b1};
          res.push_back(r);
          placed = 1'b1;
        end
      end
      if (!placed) begin
        r = '{KIND_FULL, '0, '0, '0, 1'b1};
        res.push_back(r);
      end
    end else begin
      if (w.second_value == '0) begin
        for (s = 0; s < NSLOTS; s++) begin
          if (ev_busy[s] && ev_hour[s] == w.hour_value && ev_minute[s] == w.minute_value &&
              ev_chan[s] < CHANNEL_COUNT_DEF && res.size() < MAX_RESULTS) begin
            r = '{KIND_WRITE, SLOT_IDX_W'(s), ev_chan[s], ev_level[s], 1'b0};
            res.push_back(r);
          end
        end
      end
      if (res.size() == 0) begin
        r = '{KIND_NONE, '0, '0, '0, 1'b1};
        res.push_back(r);
      end else begin
        res[res.size()-1].last_result = 1'b1;
      end
    end
  endfunction

  // mostly ticks aimed at stored times, some inserts and some noise
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick, s;
    w.hour_value    = HOUR_W'($urandom_range(31, 0));
    w.minute_value  = MINUTE_W'($urandom_range(63, 0));
    w.second_value  = SECOND_W'($urandom_range(63, 0));
    w.channel_index = CHAN_W'($urandom_range(255, 0));
    w.level_value   = LEVEL_W'($urandom_range(255, 0));
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      w.operation = OP_INSERT;
      if ($urandom_range(1, 0))
        w.channel_index = CHAN_W'($urandom_range(CHANNEL_COUNT_DEF - 1, 0));
    end else begin
      w.operation = OP_TICK;
      if (pick < 82) begin
        s = $urandom_range(NSLOTS - 1, 0);
        if (ev_busy[s]) begin
          w.hour_value   = ev_hour[s];
          w.minute_value = ev_minute[s];
        end
        w.second_value = '0;
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= w.operation;
    in_if.hour_value    <= w.hour_value;
    in_if.minute_value  <= w.minute_value;
    in_if.second_value  <= w.second_value;
    in_if.channel_index <= w.channel_index;
    in_if.level_value   <= w.level_value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : rx_proc
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99, 0) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.result_kind = kind_e'(out_if.result_kind);
      got.slot_index  = out_if.slot_index;
      got.out_channel = out_if.out_channel;
      got.out_level   = out_if.out_level;
      got.last_result = out_if.last_result;
      case (got.result_kind)
        KIND_INSERTED: n_ins++;
        KIND_FULL:     n_full++;
        KIND_WRITE:    n_writes++;
        default:       n_none++;
      endcase
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected word: kind %0d slot %0d ch %0d lvl %0d last %0b",
                               got.result_kind, got.slot_index, got.out_channel,
                               got.out_level, got.last_result));
      end else begin
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind || got.slot_index !== want.slot_index ||
            got.out_channel !== want.out_channel || got.out_level !== want.out_level ||
            got.last_result !== want.last_result)
          note_failure($sformatf({"exp kind %0d slot %0d ch %0d lvl %0d last %0b, ",
                                  "got kind %0d slot %0d ch %0d lvl %0d last %0b"},
                                 want.result_kind, want.slot_index, want.out_channel,
                                 want.out_level, want.last_result,
                                 got.result_kind, got.slot_index, got.out_channel,
                                 got.out_level, got.last_result));
      end
    end
  end

  initial begin : stim
    in_word_t    w;
    out_word_t   res [$];
    out_word_t   fixed;
    int unsigned guard;
    in_if.valid         = 1'b0;
    in_if.operation     = 1'b0;
    in_if.hour_value    = '0;
    in_if.minute_value  = '0;
    in_if.second_value  = '0;
    in_if.channel_index = '0;
    in_if.level_value   = '0;
    for (int s = 0; s < NSLOTS; s++) begin
      ev_busy[s]   = 1'b0;
      ev_hour[s]   = '0;
      ev_minute[s] = '0;
      ev_chan[s]   = '0;
      ev_level[s]  = '0;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      w.operation     = dir_rows[i].op;
      w.hour_value    = HOUR_W'(dir_rows[i].hour);
      w.minute_value  = MINUTE_W'(dir_rows[i].minute);
      w.second_value  = SECOND_W'(dir_rows[i].second);
      w.channel_index = CHAN_W'(dir_rows[i].chan);
      w.level_value   = LEVEL_W'(dir_rows[i].level);
      send_word(w);
      event_table_step(w, res);
      if (dir_rows[i].typed) begin
        fixed = '{dir_rows[i].kind, SLOT_IDX_W'(dir_rows[i].slot), '0, '0, 1'b1};
        awaited_results.push_back(fixed);
      end else begin
        foreach (res[j]) awaited_results.push_back(res[j]);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 0 && k == 40) hold_req = 1'b1;
        w = random_word();
        send_word(w);
        event_table_step(w, res);
        foreach (res[j]) awaited_results.push_back(res[j]);
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    sink_stall_pct = 0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", awaited_results.size()));

    $display("Sent %0d words (%0d directed); checked %0d inserts, %0d full, %0d writes, %0d idle",
             n_sent, NDIR, n_ins, n_full, n_writes, n_none);
    $display("Flow control: free run, 81%% src gaps, 81%% sink stalls, 14%% both, %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_cnt == 0)
      $display("timed_event_table test passed");
    else
      $display("timed_event_table test failed");
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("timed_event_table test failed");
    $finish;
  end

endmodule
